[src/cdnn_pkg.sv]
// package: widths, opcodes and sequencer states for the city distance block
package cdnn_pkg;
  localparam int MAX_CITIES = 1024;
  localparam int IDX_W = $clog2(MAX_CITIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int ANS_W = 18;
  localparam logic [ANS_W-1:0] ANS_NONE = '1;
  localparam logic [ANS_W-1:0] ANS_MAX = {1'b0, {(ANS_W-1){1'b1}}};

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_LOAD    = 3'd1,
    OP_MARK    = 3'd2,
    OP_UNMARK  = 3'd3,
    OP_QVIS    = 3'd4,
    OP_DIST    = 3'd5,
    OP_NEAREST = 3'd6,
    OP_NONE    = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRC,
    ST_CAND,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_ROOT,
    ST_ROUND,
    ST_OUT
  } state_t;
endpackage

[src/city_distance_nearest_neighbor.sv]
// top level: city store with distance and nearest neighbor queries
//
// input channel in_valid/in_stall carries one item: opcode, city_a, city_b,
// coord_x, coord_y. the result channel out_valid/out_stall carries
// answer_value and visited_flag, one result for query visited, distance
// and nearest, none for the other opcodes.
// items are taken one at a time; in_stall is high while an item is at work
// or its result waits in the output register.
// clear, load, mark, unmark finish when taken, the next item can follow at once.
// a query goes through the source read and then the output register; distance
// adds the difference, square, sum, the bit-serial square root (one root bit
// per cycle) and rounding; nearest takes one candidate at a time
// through the coordinate memory read port, the squarer and the root unit.
// coordinates and visited marks live in synchronous memories with a registered
// read; a memory entry is undefined until its city is loaded.
// reset (synchronous, rst_n low) empties the store and drops any pending
// result. a stalled result holds until out_stall goes low.
module city_distance_nearest_neighbor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_opcode,
  input  logic [cdnn_pkg::IDX_W-1:0]      in_city_a,
  input  logic [cdnn_pkg::IDX_W-1:0]      in_city_b,
  input  logic signed [cdnn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [cdnn_pkg::COORD_W-1:0] in_coord_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [cdnn_pkg::ANS_W-1:0] out_answer_value,
  output logic                            out_visited_flag
);
  import cdnn_pkg::*;

  logic [2*COORD_W-1:0] coord_mem [MAX_CITIES];
  logic                 vis_mem [MAX_CITIES];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  opcode_t op_r, op_nxt;
  logic [IDX_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] best_i_r, best_i_nxt;
  logic [ANS_W-1:0] best_d_r, best_d_nxt;
  logic have_r, have_nxt;
  logic signed [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [SQ_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [SUM_W-1:0] s_r, s_nxt, rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [$clog2(ROOT_W+1)-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ANS_W-1:0] ans_r, ans_nxt;
  logic flag_r, flag_nxt;

  logic mem_we, vis_we, vis_wd;
  logic [IDX_W-1:0] mem_waddr, vis_waddr, rd_addr;
  logic [2*COORD_W-1:0] rd_coord;
  logic rd_vis;

  always_ff @(posedge clk) begin
    if (mem_we) coord_mem[mem_waddr] <= {in_coord_x, in_coord_y};
    if (vis_we) vis_mem[vis_waddr] <= vis_wd;
    rd_coord <= coord_mem[rd_addr];
    rd_vis <= vis_mem[rd_addr];
  end

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_answer_value = ans_r;
  assign out_visited_flag = flag_r;

  logic signed [DIFF_W-1:0] ddx, ddy;
  logic [SUM_W+1:0] trial;
  logic [ROOT_W:0] rnd;
  logic [ANS_W-1:0] dist_val;
  logic [SUM_W:0] rr;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    op_nxt = op_r;
    ca_nxt = ca_r;
    cb_nxt = cb_r;
    idx_nxt = idx_r;
    best_i_nxt = best_i_r;
    best_d_nxt = best_d_r;
    have_nxt = have_r;
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    qx_nxt = qx_r;
    qy_nxt = qy_r;
    s_nxt = s_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    ans_nxt = ans_r;
    flag_nxt = flag_r;
    mem_we = 1'b0;
    vis_we = 1'b0;
    vis_wd = 1'b0;
    mem_waddr = in_city_a;
    vis_waddr = in_city_a;
    rd_addr = ca_r;
    ddx = $signed({sx_r[COORD_W-1], sx_r}) - $signed({rd_coord[2*COORD_W-1],
          rd_coord[2*COORD_W-1:COORD_W]});
    ddy = $signed({sy_r[COORD_W-1], sy_r}) - $signed({rd_coord[COORD_W-1],
          rd_coord[COORD_W-1:0]});
    trial = {rem_r[SUM_W-2:0], s_r[SUM_W-1 -: 2]} - {root_r, 2'b01};
    rr = {1'b0, ({{(SUM_W-ROOT_W){1'b0}}, root_r} * {{(SUM_W-ROOT_W){1'b0}}, root_r})}
         + {{(SUM_W+1-ROOT_W){1'b0}}, root_r};
    rnd = {1'b0, root_r} + {{ROOT_W{1'b0}}, ({1'b0, s_r} > rr)};
    dist_val = (rnd > ROOT_W'(ANS_MAX)) ? ANS_MAX : ANS_W'(rnd);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt = opcode_t'(in_opcode);
          ca_nxt = in_city_a;
          cb_nxt = in_city_b;
          rd_addr = in_city_a;
          unique case (opcode_t'(in_opcode))
            OP_CLEAR: count_nxt = '0;
            OP_LOAD: begin
              if ({1'b0, in_city_a} == count_r && count_r < CNT_W'(MAX_CITIES)) begin
                mem_we = 1'b1;
                vis_we = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_MARK, OP_UNMARK: begin
              vis_we = {1'b0, in_city_a} < count_r;
              vis_wd = opcode_t'(in_opcode) == OP_MARK;
            end
            OP_QVIS, OP_DIST, OP_NEAREST: state_nxt = ST_SRC;
            default: ;
          endcase
        end
      end
      ST_SRC: begin
        sx_nxt = rd_coord[2*COORD_W-1:COORD_W];
        sy_nxt = rd_coord[COORD_W-1:0];
        have_nxt = 1'b0;
        idx_nxt = '0;
        ans_nxt = ANS_NONE;
        flag_nxt = 1'b0;
        state_nxt = ST_OUT;
        if (op_r == OP_QVIS) begin
          ans_nxt = '0;
          flag_nxt = ({1'b0, ca_r} < count_r) && rd_vis;
        end else if (op_r == OP_DIST) begin
          if ({1'b0, ca_r} < count_r && {1'b0, cb_r} < count_r) begin
            rd_addr = cb_r;
            state_nxt = ST_DIFF;
          end
        end else if ({1'b0, ca_r} < count_r && !rd_vis) begin
          state_nxt = ST_CAND;
        end
      end
      ST_CAND: begin
        if (idx_r >= count_r) begin
          if (have_r) ans_nxt = {{(ANS_W-IDX_W){1'b0}}, best_i_r};
          state_nxt = ST_OUT;
        end else if (idx_r[IDX_W-1:0] == ca_r) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          rd_addr = idx_r[IDX_W-1:0];
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        dx_nxt = ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
        dy_nxt = ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        qx_nxt = dx_r * dx_r;
        qy_nxt = dy_r * dy_r;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        s_nxt = {2'b00, qx_r} + {2'b00, qy_r};
        rem_nxt = '0;
        root_nxt = '0;
        step_nxt = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        // one root bit per cycle, restoring method
        if (!trial[SUM_W+1]) begin
          rem_nxt = trial[SUM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[SUM_W-3:0], s_r[SUM_W-1 -: 2]};
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        s_nxt = {s_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == ($clog2(ROOT_W+1))'(ROOT_W-1)) begin
          s_nxt = {2'b00, qx_r} + {2'b00, qy_r};
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (op_r == OP_DIST) begin
          ans_nxt = dist_val;
          state_nxt = ST_OUT;
        end else begin
          if (!have_r || dist_val < best_d_r) begin
            have_nxt = 1'b1;
            best_d_nxt = dist_val;
            best_i_nxt = idx_r[IDX_W-1:0];
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = ST_CAND;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    ca_r <= ca_nxt;
    cb_r <= cb_nxt;
    idx_r <= idx_nxt;
    best_i_r <= best_i_nxt;
    best_d_r <= best_d_nxt;
    have_r <= have_nxt;
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    qx_r <= qx_nxt;
    qy_r <= qy_nxt;
    s_r <= s_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    step_r <= step_nxt;
    ans_r <= ans_nxt;
    flag_r <= flag_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CITIES)) else $error("city count above capacity");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("item taken while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT) else $error("stray result");
  a_flag_only_qvis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flag_r |-> ans_r == '0) else $error("flag with answer");
endmodule

[dv/city_distance_nearest_neighbor_checker.sv]
// checker: predicts each query answer from the accepted items and compares the results
`timescale 1ns / 100ps
module city_distance_nearest_neighbor_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [2:0]                          in_opcode,
  input  logic [cdnn_pkg::IDX_W-1:0]          in_city_a,
  input  logic [cdnn_pkg::IDX_W-1:0]          in_city_b,
  input  logic signed [cdnn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [cdnn_pkg::COORD_W-1:0] in_coord_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [cdnn_pkg::ANS_W-1:0]   out_answer_value,
  input  logic                                out_visited_flag,
  output int                                  fail_count,
  output int                                  pending_count
);
  import cdnn_pkg::*;

  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic             flag;
  } answer_t;

  answer_t                  answer_q[$];
  logic signed [COORD_W-1:0] city_x[MAX_CITIES];
  logic signed [COORD_W-1:0] city_y[MAX_CITIES];
  bit                       visited[MAX_CITIES];
  int                       city_count;

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > s) probe = probe >> 2;
    while (probe != 0) begin
      if (s >= root + probe) begin
        s = s - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic logic [ANS_W-1:0] rounded_distance(int a, int b);
    longint dx;
    longint dy;
    longint unsigned s;
    longint unsigned r;
    dx = longint'(city_x[a]) - longint'(city_x[b]);
    dy = longint'(city_y[a]) - longint'(city_y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    s = dx * dx + dy * dy;
    r = int_sqrt(s);
    if (s > r * r + r) r++;
    if (r > ANS_MAX) r = ANS_MAX;
    return r[ANS_W-1:0];
  endfunction

  task automatic enqueue_answer(answer_t e);
    answer_q.insert(answer_q.size(), e);
  endtask

  task automatic predict_item(opcode_t op, int a, int b,
                              logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    answer_t          e;
    logic [ANS_W-1:0] best;
    bit               have;
    logic [ANS_W-1:0] d;
    e.answer = ANS_NONE;
    e.flag = 1'b0;
    case (op)
      OP_CLEAR: city_count = 0;
      OP_LOAD: begin
        if (a == city_count && city_count < MAX_CITIES) begin
          city_x[a] = x;
          city_y[a] = y;
          visited[a] = 1'b0;
          city_count++;
        end
      end
      OP_MARK, OP_UNMARK: begin
        if (a < city_count) visited[a] = (op == OP_MARK);
      end
      OP_QVIS: begin
        e.answer = '0;
        e.flag = (a < city_count) && visited[a];
        enqueue_answer(e);
      end
      OP_DIST: begin
        if (a < city_count && b < city_count) e.answer = rounded_distance(a, b);
        enqueue_answer(e);
      end
      OP_NEAREST: begin
        if (a < city_count && !visited[a]) begin
          have = 0;
          best = '0;
          for (int i = 0; i < city_count; i++) begin
            if (i != a) begin
              d = rounded_distance(a, i);
              if (!have || d < best) begin
                have = 1;
                best = d;
                e.answer = ANS_W'(i);
              end
            end
          end
        end
        enqueue_answer(e);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    answer_t e;
    if (answer_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: answer %0d flag %0b", out_answer_value, out_visited_flag);
    end else begin
      e = answer_q.pop_front();
      if (e.answer !== out_answer_value || e.flag !== out_visited_flag) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected answer %0d flag %0b, got answer %0d flag %0b",
                   $signed(e.answer), e.flag, out_answer_value, out_visited_flag);
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    city_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      city_count = 0;
      answer_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        predict_item(opcode_t'(in_opcode), in_city_a, in_city_b, in_coord_x, in_coord_y);
    end
    pending_count = answer_q.size();
  end

endmodule

[dv/city_distance_nearest_neighbor_test.sv]
// testbench top: clock, reset, item stimulus, result stalls and the verdict
`timescale 1ns / 100ps
module city_distance_nearest_neighbor_test;
  import cdnn_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [2:0]                in_opcode;
  logic [IDX_W-1:0]          in_city_a;
  logic [IDX_W-1:0]          in_city_b;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [ANS_W-1:0]   out_answer_value;
  logic                      out_visited_flag;
  int                        fail_count;
  int                        pending_count;
  bit                        no_gaps;
  int                        item_count;
  int                        load_count;

  city_distance_nearest_neighbor u_dut (.*);

  city_distance_nearest_neighbor_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return COORD_W'($urandom_range(0, 40)) - 16'd20;
      default: return COORD_W'($urandom());
    endcase
  endfunction

  task automatic send_item(opcode_t op, int a, int b, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y);
    int gap;
    gap = no_gaps ? 0 : gap_length();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = op;
    in_city_a = a[IDX_W-1:0];
    in_city_b = b[IDX_W-1:0];
    in_coord_x = x;
    in_coord_y = y;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    item_count++;
  endtask

  task automatic pick_city(output int c);
    case ($urandom_range(0, 9))
      0: c = $urandom_range(0, 1023);
      1: c = load_count + $urandom_range(0, 2);
      default: c = (load_count > 0) ? $urandom_range(0, load_count - 1) : 0;
    endcase
  endtask

  task automatic random_phase();
    int n;
    int a;
    int b;
    int ops;
    opcode_t op;
    if ($urandom_range(0, 4) != 0) begin
      send_item(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                COORD_W'($urandom()), COORD_W'($urandom()));
      load_count = 0;
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
    for (int i = 0; i < n && load_count < MAX_CITIES; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(OP_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023), rand_coord(),
                  rand_coord());
      send_item(OP_LOAD, load_count, $urandom_range(0, 1023), rand_coord(), rand_coord());
      load_count++;
    end
    ops = $urandom_range(5, 20);
    repeat (ops) begin
      pick_city(a);
      pick_city(b);
      case ($urandom_range(0, 15))
        0, 1: op = OP_MARK;
        2, 3: op = OP_UNMARK;
        4, 5, 6: op = OP_QVIS;
        7, 8, 9, 10: op = OP_DIST;
        15: op = ($urandom_range(0, 1) == 0) ? OP_NONE : OP_LOAD;
        default: op = OP_NEAREST;
      endcase
      send_item(op, a, b, rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_CLEAR;
    in_city_a = '0;
    in_city_b = '0;
    in_coord_x = '0;
    in_coord_y = '0;
    no_gaps = 0;
    item_count = 0;
    load_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // empty store, extremes, ties, visited source, ignored items
    send_item(OP_QVIS, 0, 0, 0, 0);
    send_item(OP_DIST, 0, 0, 0, 0);
    send_item(OP_NEAREST, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, 1023, 16'h8000, 16'h7fff);
    send_item(OP_LOAD, 5, 0, 16'h1234, 16'h4321);
    send_item(OP_LOAD, 1, 0, 16'h7fff, 16'h8000);
    send_item(OP_NEAREST, 0, 0, 0, 0);
    send_item(OP_DIST, 0, 1, 0, 0);
    send_item(OP_LOAD, 2, 0, 0, 0);
    send_item(OP_LOAD, 2, 0, 16'h0055, 16'h0055);
    send_item(OP_LOAD, 3, 0, 16'd100, 0);
    send_item(OP_LOAD, 4, 0, -16'sd100, 0);
    send_item(OP_NEAREST, 2, 0, 0, 0);
    send_item(OP_MARK, 0, 0, 0, 0);
    send_item(OP_QVIS, 0, 0, 0, 0);
    send_item(OP_NEAREST, 0, 0, 0, 0);
    send_item(OP_MARK, 1023, 0, 0, 0);
    send_item(OP_QVIS, 1023, 0, 0, 0);
    send_item(OP_UNMARK, 0, 0, 0, 0);
    send_item(OP_QVIS, 0, 0, 0, 0);
    send_item(OP_DIST, 0, 1023, 0, 0);
    send_item(OP_NONE, 1023, 1023, 16'hffff, 16'hffff);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, 0, 16'd7, 16'd7);
    send_item(OP_NEAREST, 0, 0, 0, 0);
    load_count = 1;

    while (item_count < 540) random_phase();
    in_valid = 0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall = 0;
      repeat (gap_length() + $urandom_range(0, 4)) @(negedge clk);
      out_stall = 1;
      repeat (gap_length()) @(negedge clk);
    end
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
